@@ hdl/tdc_event_word_unpacker_top_assert.svh @@
// Assertion macros used by the unpacker checker file.
`ifndef TDC_EVENT_WORD_UNPACKER_TOP_ASSERT_SVH
`define TDC_EVENT_WORD_UNPACKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tdu_pkg.sv @@
// Types and constants of the TDC event word unpacker.
`timescale 1ns / 1ps
`default_nettype none

package tdu_pkg;

    // Type codes in bits 15..12 of the high half
    localparam logic [3:0] TYPE_HEADER  = 4'h4;
    localparam logic [3:0] TYPE_DATUM   = 4'h0;
    localparam logic [3:0] TYPE_TRAILER = 4'hC;

    // Module id reported once the header or a datum was bad
    localparam logic [7:0] BAD_ID = 8'd99;

    // Event parsing phase
    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_DATA    = 3'b010,
        PH_TRAILER = 3'b100
    } phase_t;

    // One readout word
    typedef struct packed {
        logic [15:0] low_half;
        logic [15:0] high_half;
    } word_t;

    // One result record
    typedef struct packed {
        logic        is_end;
        logic [4:0]  channel;
        logic [15:0] value;
        logic [7:0]  module_id;
        logic [3:0]  resolution;
        logic        error;
    } hit_t;

endpackage

`default_nettype wire

@@ hdl/tdu_ifs.sv @@
// Channel interfaces: readout words in, hit records out, config writes.
`timescale 1ns / 1ps
`default_nettype none

interface tdu_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] low_half;
    logic [15:0] high_half;

    modport source (output valid, output low_half, output high_half, input ready);
    modport sink   (input valid, input low_half, input high_half, output ready);
endinterface

interface tdu_hit_if;
    logic        valid;
    logic        ready;
    logic        is_end;
    logic [4:0]  channel;
    logic [15:0] value;
    logic [7:0]  module_id;
    logic [3:0]  resolution;
    logic        error;

    modport source (output valid, output is_end, output channel, output value,
                    output module_id, output resolution, output error, input ready);
    modport sink   (input valid, input is_end, input channel, input value,
                    input module_id, input resolution, input error, output ready);
endinterface

interface tdu_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/tdu_core.sv @@
// Event state registers and per-word decode of the unpacker.
`timescale 1ns / 1ps
`default_nettype none

module tdu_core
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire tdu_pkg::word_t word,
    input  wire logic [7:0]    expected_id,
    output tdu_pkg::hit_t      result,
    output logic               has_result
);

    tdu_pkg::phase_t phase_reg, phase_next;
    logic [9:0]      words_left_reg, words_left_next;
    logic [7:0]      event_id_reg, event_id_next;
    logic [3:0]      event_res_reg, event_res_next;
    logic            skipping_reg, skipping_next;
    logic            event_error_reg, event_error_next;

    logic [3:0]      word_type;
    logic [9:0]      count;
    logic [9:0]      left_dec;

    assign word_type = word.high_half[15:12];
    assign count     = word.low_half[9:0];
    assign left_dec  = words_left_reg - 10'd1;

    // Decode one word against the current event state
    always_comb
    begin
        phase_next       = phase_reg;
        words_left_next  = words_left_reg;
        event_id_next    = event_id_reg;
        event_res_next   = event_res_reg;
        skipping_next    = skipping_reg;
        event_error_next = event_error_reg;
        has_result       = 1'b0;
        result           = '0;

        unique case (phase_reg)
            tdu_pkg::PH_HEADER:
            begin
                if (word_type != tdu_pkg::TYPE_HEADER)
                begin
                    // bad header: one error hit, go straight to the trailer
                    event_res_next   = 4'd0;
                    event_id_next    = tdu_pkg::BAD_ID;
                    event_error_next = 1'b1;
                    skipping_next    = (tdu_pkg::BAD_ID != expected_id);
                    words_left_next  = 10'd0;
                    phase_next       = tdu_pkg::PH_TRAILER;
                    has_result       = 1'b1;
                    result.module_id = tdu_pkg::BAD_ID;
                    result.error     = 1'b1;
                end
                else
                begin
                    // count includes the trailer; zero counts as one
                    words_left_next  = (count == 10'd0) ? 10'd0 : count - 10'd1;
                    event_res_next   = word.low_half[15:12];
                    event_id_next    = word.high_half[7:0];
                    skipping_next    = (word.high_half[7:0] != expected_id);
                    event_error_next = (word.high_half[7:0] != expected_id);
                    phase_next       = (count <= 10'd1) ? tdu_pkg::PH_TRAILER
                                                        : tdu_pkg::PH_DATA;
                end
            end

            tdu_pkg::PH_DATA:
            begin
                if (!skipping_reg)
                begin
                    has_result = 1'b1;
                    if (word_type != tdu_pkg::TYPE_DATUM)
                    begin
                        event_id_next    = tdu_pkg::BAD_ID;
                        event_res_next   = 4'd0;
                        event_error_next = 1'b1;
                        result.module_id = tdu_pkg::BAD_ID;
                        result.error     = 1'b1;
                    end
                    else
                    begin
                        result.channel    = word.high_half[4:0];
                        result.value      = word.low_half;
                        result.module_id  = event_id_reg;
                        result.resolution = event_res_reg;
                        result.error      = event_error_reg;
                    end
                end
                words_left_next = left_dec;
                if (left_dec == 10'd0)
                begin
                    phase_next = tdu_pkg::PH_TRAILER;
                end
            end

            default:
            begin
                // trailer position: any word here closes the event
                has_result        = 1'b1;
                result.is_end     = 1'b1;
                result.module_id  = event_id_reg;
                result.resolution = event_res_reg;
                result.error      = event_error_reg | (word_type != tdu_pkg::TYPE_TRAILER);
                phase_next        = tdu_pkg::PH_HEADER;
                words_left_next   = 10'd0;
                event_id_next     = 8'd0;
                event_res_next    = 4'd0;
                skipping_next     = 1'b0;
                event_error_next  = 1'b0;
            end
        endcase
    end

    // Event state update on each word that leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tdu_pkg::PH_HEADER;
            words_left_reg  <= 10'd0;
            event_id_reg    <= 8'd0;
            event_res_reg   <= 4'd0;
            skipping_reg    <= 1'b0;
            event_error_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            words_left_reg  <= words_left_next;
            event_id_reg    <= event_id_next;
            event_res_reg   <= event_res_next;
            skipping_reg    <= skipping_next;
            event_error_reg <= event_error_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tdc_event_word_unpacker_top.sv @@
// Top level of the TDC event word unpacker.
// Usage:
//   words: one 32-bit readout word per transaction (low_half first stored,
//          high_half second). Events are header, data words, trailer.
//   hits:  at most one record per word: a channel/value hit, an error hit,
//          or an end-of-event record (is_end = 1).
//   cfg:   writes expected_id; always ready. Write only while idle.
// Path: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle while the record output is not stalled; the event
//   state update is a single pass of mask, compare and 10-bit decrement logic.
// Headers and skipped data words (those of a foreign module id) produce no
//   record; they clear the result valid but leave the stored record as is.
// Reset: event parsing returns to expecting a header, expected_id clears
//   to zero, both pipeline stages empty.
// Stall: while hits.ready is low the record holds; one further word can
//   sit in the input register, after which words.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module tdc_event_word_unpacker_top
(
    input  wire logic clk,
    input  wire logic rst_n,
    tdu_word_if.sink  words,
    tdu_hit_if.source hits,
    tdu_cfg_if.sink   cfg
);

    logic            in_valid_reg;
    tdu_pkg::word_t  in_word_reg;
    logic            out_valid_reg;
    tdu_pkg::hit_t   out_hit_reg;
    logic [7:0]      expected_id_reg;

    logic            advance;
    logic            has_result;
    tdu_pkg::hit_t   result;

    // Input stage moves on whenever the result register is free or draining
    assign advance     = in_valid_reg && (!out_valid_reg || hits.ready);
    assign words.ready = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= 8'd0;
        end
        else if (cfg.valid)
        begin
            expected_id_reg <= cfg.data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (words.ready)
        begin
            in_valid_reg <= words.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (words.valid && words.ready)
        begin
            in_word_reg.low_half  <= words.low_half;
            in_word_reg.high_half <= words.high_half;
        end
    end

    tdu_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .word        (in_word_reg),
        .expected_id (expected_id_reg),
        .result      (result),
        .has_result  (has_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= has_result;
        end
        else if (hits.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_hit_reg <= result;
        end
    end

    assign hits.valid      = out_valid_reg;
    assign hits.is_end     = out_hit_reg.is_end;
    assign hits.channel    = out_hit_reg.channel;
    assign hits.value      = out_hit_reg.value;
    assign hits.module_id  = out_hit_reg.module_id;
    assign hits.resolution = out_hit_reg.resolution;
    assign hits.error      = out_hit_reg.error;

endmodule

`default_nettype wire

@@ hdl/tdu_checker.sv @@
// Port-level checker for the unpacker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "tdc_event_word_unpacker_top_assert.svh"

module tdu_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        word_valid,
    input wire logic        word_ready,
    input wire logic        hit_valid,
    input wire logic        hit_ready,
    input wire logic        hit_is_end,
    input wire logic [4:0]  hit_channel,
    input wire logic [15:0] hit_value,
    input wire logic [7:0]  hit_module_id,
    input wire logic [3:0]  hit_resolution,
    input wire logic        hit_error
);

    logic [34:0] hit_payload;

    assign hit_payload = {hit_is_end, hit_channel, hit_value, hit_module_id,
                          hit_resolution, hit_error};

    // A stalled record stays put
    `TDU_ASSERT_NEXT(a_hit_hold, hit_valid && !hit_ready, hit_valid && $stable(hit_payload), "record changed while stalled")

    // Input back-pressure only comes from a record waiting at the output
    `TDU_ASSERT_NOW(a_ready_cause, !word_ready, hit_valid, "input stalled with empty output")

    // A fresh record traces back to an accepted word that passed the input and result registers
    `TDU_ASSERT_NOW(a_hit_origin, $rose(hit_valid), $past(word_valid && word_ready, 2), "record without a source word")

endmodule

bind tdc_event_word_unpacker_top tdu_checker u_tdu_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .word_valid     (words.valid),
    .word_ready     (words.ready),
    .hit_valid      (hits.valid),
    .hit_ready      (hits.ready),
    .hit_is_end     (hits.is_end),
    .hit_channel    (hits.channel),
    .hit_value      (hits.value),
    .hit_module_id  (hits.module_id),
    .hit_resolution (hits.resolution),
    .hit_error      (hits.error)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench of the TDC event word unpacker: event streams against a scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_WORDS = 500;
    localparam int CFG_EVERY    = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 50;

    // Event unpacking predictor and record scoreboard
    class hit_scoreboard;
        tdu_pkg::phase_t phase;
        logic [9:0]      words_left;
        logic [7:0]      event_id;
        logic [3:0]      event_res;
        logic            skipping;
        logic            event_err;
        logic [7:0]      expected_id;
        tdu_pkg::hit_t   pending_hits[$];
        int              errors;
        int              checked;

        function new();
            clear_event();
            expected_id = 8'd0;
            errors = 0;
            checked = 0;
        endfunction

        function void clear_event();
            phase = tdu_pkg::PH_HEADER;
            words_left = 10'd0;
            event_id = 8'd0;
            event_res = 4'd0;
            skipping = 1'b0;
            event_err = 1'b0;
        endfunction

        function void push_hit(logic is_end, logic [4:0] ch, logic [15:0] val,
                               logic [7:0] id, logic [3:0] res, logic err);
            tdu_pkg::hit_t h;
            h.is_end = is_end;
            h.channel = ch;
            h.value = val;
            h.module_id = id;
            h.resolution = res;
            h.error = err;
            pending_hits.insert(pending_hits.size(), h);
        endfunction

        // Advance the event state by one accepted readout word
        function void note_word(logic [15:0] lo, logic [15:0] hi);
            logic [3:0] kind;
            logic [9:0] count;
            kind = hi[15:12];
            case (phase)
                tdu_pkg::PH_HEADER:
                begin
                    if (kind != tdu_pkg::TYPE_HEADER)
                    begin
                        event_res = 4'd0;
                        event_id = tdu_pkg::BAD_ID;
                        event_err = 1'b1;
                        skipping = (tdu_pkg::BAD_ID != expected_id);
                        words_left = 10'd0;
                        phase = tdu_pkg::PH_TRAILER;
                        push_hit(1'b0, 5'd0, 16'd0, tdu_pkg::BAD_ID, 4'd0, 1'b1);
                    end
                    else
                    begin
                        count = lo[9:0];
                        if (count == 10'd0)
                            count = 10'd1;
                        event_res = lo[15:12];
                        event_id = hi[7:0];
                        words_left = count - 10'd1;
                        event_err = 1'b0;
                        skipping = 1'b0;
                        if (event_id != expected_id)
                        begin
                            skipping = 1'b1;
                            event_err = 1'b1;
                        end
                        phase = (words_left == 10'd0) ? tdu_pkg::PH_TRAILER
                                                      : tdu_pkg::PH_DATA;
                    end
                end
                tdu_pkg::PH_DATA:
                begin
                    if (!skipping)
                    begin
                        if (kind != tdu_pkg::TYPE_DATUM)
                        begin
                            event_id = tdu_pkg::BAD_ID;
                            event_res = 4'd0;
                            event_err = 1'b1;
                            push_hit(1'b0, 5'd0, 16'd0, tdu_pkg::BAD_ID, 4'd0, 1'b1);
                        end
                        else
                            push_hit(1'b0, hi[4:0], lo, event_id, event_res, event_err);
                    end
                    words_left = words_left - 10'd1;
                    if (words_left == 10'd0)
                        phase = tdu_pkg::PH_TRAILER;
                end
                default:
                begin
                    // any word in trailer position closes the event
                    push_hit(1'b1, 5'd0, 16'd0, event_id, event_res,
                             event_err | (kind != tdu_pkg::TYPE_TRAILER));
                    clear_event();
                end
            endcase
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                             $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted record with the oldest pending one
        function void check_hit(logic is_end, logic [4:0] ch, logic [15:0] val,
                                logic [7:0] id, logic [3:0] res, logic err);
            tdu_pkg::hit_t want;
            if (pending_hits.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected record: expected none, actual end=%0b ch=%0d val=0x%0h",
                             $time, is_end, ch, val);
                errors++;
            end
            else
            begin
                want = pending_hits.pop_front();
                checked++;
                check_field("is_end", want.is_end, is_end);
                check_field("channel", want.channel, ch);
                check_field("value", want.value, val);
                check_field("module_id", want.module_id, id);
                check_field("resolution", want.resolution, res);
                check_field("error", want.error, err);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int unsigned cycle_count = 0;
    int unsigned words_sent;
    int unsigned burst_left;
    int unsigned cfg_writes;
    hit_scoreboard sb;

    tdu_word_if word_bus ();
    tdu_hit_if  hit_bus ();
    tdu_cfg_if  cfg_bus ();

    tdc_event_word_unpacker_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .words (word_bus),
        .hits  (hit_bus),
        .cfg   (cfg_bus)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle count and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL tdc_event_word_unpacker_top");
            $finish;
        end
    end

    // Receiver stall pattern: free, periodic, random, long stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            hit_bus.ready <= 1'b0;
        else
            case (cycle_count[9:8])
                2'd0: hit_bus.ready <= 1'b1;
                2'd1: hit_bus.ready <= (cycle_count % 7) < 4;
                2'd2: hit_bus.ready <= 1'($urandom_range(0, 1));
                default: hit_bus.ready <= (cycle_count % 40) >= 25;
            endcase
    end

    // Record monitor
    always @(posedge clk)
    begin
        if (rst_n && hit_bus.valid && hit_bus.ready)
            sb.check_hit(hit_bus.is_end, hit_bus.channel, hit_bus.value,
                         hit_bus.module_id, hit_bus.resolution, hit_bus.error);
    end

    // One readout word transaction, sent in bursts with random gaps
    task automatic send_word(input logic [15:0] lo, input logic [15:0] hi);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                word_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        word_bus.valid <= 1'b1;
        word_bus.low_half <= lo;
        word_bus.high_half <= hi;
        do
            @(posedge clk);
        while (!word_bus.ready);
        burst_left--;
        words_sent++;
        sb.note_word(lo, hi);
    endtask

    // Hold off input until every pending record has arrived
    task automatic wait_drain();
        word_bus.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_expected_id(input logic [7:0] id);
        wait_drain();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data <= id;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        sb.expected_id = id;
        cfg_writes++;
    endtask

    // Header, n_data data words and trailer, with occasional bad types
    task automatic send_event(input logic [7:0] id, input int unsigned n_data);
        int unsigned count;
        logic [3:0]  kind;
        logic [15:0] val;
        count = n_data + 1;
        if (n_data == 0 && $urandom_range(0, 1) == 1)
            count = 0;
        send_word({4'($urandom), 2'($urandom), 10'(count)},
                  {tdu_pkg::TYPE_HEADER, 4'($urandom), id});
        for (int i = 0; i < n_data; i++)
        begin
            kind = tdu_pkg::TYPE_DATUM;
            if ($urandom_range(0, 19) == 0)
                do
                    kind = 4'($urandom);
                while (kind == tdu_pkg::TYPE_DATUM);
            case ($urandom_range(0, 9))
                0: val = 16'h0000;
                1: val = 16'hffff;
                default: val = 16'($urandom);
            endcase
            send_word(val, {kind, 7'($urandom), 5'($urandom)});
        end
        kind = tdu_pkg::TYPE_TRAILER;
        if ($urandom_range(0, 9) == 0)
            do
                kind = 4'($urandom);
            while (kind == tdu_pkg::TYPE_TRAILER);
        send_word(16'($urandom), {kind, 12'($urandom)});
    endtask

    initial
    begin
        int unsigned base;
        int unsigned next_cfg;
        int unsigned pick;
        int unsigned cfg_round;
        logic [3:0]  kind;
        logic [7:0]  id;

        sb = new();
        words_sent = 0;
        burst_left = 0;
        cfg_writes = 0;
        rst_n <= 1'b0;
        word_bus.valid <= 1'b0;
        word_bus.low_half <= 16'd0;
        word_bus.high_half <= 16'd0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data <= 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: count of zero, field extremes, every error path
        write_expected_id(8'd0);
        send_word({4'hf, 2'b00, 10'd0}, {tdu_pkg::TYPE_HEADER, 4'h0, 8'd0});
        send_word(16'h0000, {tdu_pkg::TYPE_TRAILER, 12'h000});
        send_word({4'h0, 2'b00, 10'd3}, {tdu_pkg::TYPE_HEADER, 4'h0, 8'd0});
        send_word(16'hffff, {tdu_pkg::TYPE_DATUM, 7'h7f, 5'd31});
        send_word(16'h0000, {tdu_pkg::TYPE_DATUM, 7'h00, 5'd0});
        send_word(16'hffff, {tdu_pkg::TYPE_TRAILER, 12'hfff});
        // bad data type, then a good datum, then a bad trailer type
        send_word({4'h5, 2'b00, 10'd3}, {tdu_pkg::TYPE_HEADER, 4'h0, 8'd0});
        send_word(16'h1234, {tdu_pkg::TYPE_TRAILER, 12'h003});
        send_word(16'h5678, {tdu_pkg::TYPE_DATUM, 7'h00, 5'd7});
        send_word(16'h0000, {tdu_pkg::TYPE_DATUM, 12'h000});
        // bad header type, then its trailer
        send_word(16'hffff, {4'hf, 12'hfff});
        send_word(16'h0000, {tdu_pkg::TYPE_TRAILER, 12'h000});
        // foreign module id: data words consumed silently
        send_word({4'h3, 2'b00, 10'd3}, {tdu_pkg::TYPE_HEADER, 4'h0, 8'd5});
        send_word(16'haaaa, {tdu_pkg::TYPE_DATUM, 7'h00, 5'd1});
        send_word(16'h5555, {tdu_pkg::TYPE_DATUM, 7'h00, 5'd2});
        send_word(16'h0000, {tdu_pkg::TYPE_TRAILER, 12'h000});
        // unused count bits set in the header
        send_word({4'ha, 2'b11, 10'd2}, {tdu_pkg::TYPE_HEADER, 4'hf, 8'd0});
        send_word(16'h0f0f, {tdu_pkg::TYPE_DATUM, 7'h55, 5'd16});
        send_word(16'h0000, {tdu_pkg::TYPE_TRAILER, 12'h000});
        write_expected_id(8'd255);
        send_word({4'hf, 2'b00, 10'd1}, {tdu_pkg::TYPE_HEADER, 4'h0, 8'd255});
        send_word(16'h0000, {tdu_pkg::TYPE_TRAILER, 12'h000});
        write_expected_id(tdu_pkg::BAD_ID);
        send_word(16'h0000, {tdu_pkg::TYPE_DATUM, 12'h000});
        send_word(16'h0000, {tdu_pkg::TYPE_TRAILER, 12'h000});

        // One event with the largest word count
        write_expected_id(8'($urandom));
        send_event(sb.expected_id, 1022);

        // Random event streams with noise, expected_id changed between phases
        base = words_sent;
        next_cfg = CFG_EVERY;
        cfg_round = 0;
        while (words_sent - base < RANDOM_WORDS)
        begin
            if (words_sent - base >= next_cfg)
            begin
                case (cfg_round % 4)
                    0: write_expected_id(8'd255);
                    1: write_expected_id(8'd0);
                    2: write_expected_id(tdu_pkg::BAD_ID);
                    default: write_expected_id(8'($urandom));
                endcase
                cfg_round++;
                next_cfg += CFG_EVERY;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_word(16'($urandom), 16'($urandom));
            else if (pick < 14)
            begin
                do
                    kind = 4'($urandom);
                while (kind == tdu_pkg::TYPE_HEADER);
                send_word(16'($urandom), {kind, 12'($urandom)});
                send_word(16'($urandom), {tdu_pkg::TYPE_TRAILER, 12'($urandom)});
            end
            else
            begin
                id = (pick < 78) ? sb.expected_id : 8'($urandom);
                send_event(id, ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60)
                                                           : $urandom_range(0, 6));
            end
        end

        wait_drain();
        $display("Run covered %0d readout words and %0d checked records", words_sent, sb.checked);
        $display("across %0d expected_id settings with sender gaps and receiver stalls",
                 cfg_writes);
        if (sb.errors == 0)
            $display("PASS tdc_event_word_unpacker_top");
        else
            $display("FAIL tdc_event_word_unpacker_top");
        $finish;
    end

endmodule
